// ----- rtl/kfb_pkg.sv -----
// kfb_pkg: shared constants, state codes and the base64 alphabet for the
// keyframe metadata bcd/base64 packer
// no dependencies
package kfb_pkg;

	localparam int TS_W             = 33;
	localparam int LEN_W            = 31;
	localparam int DIGITS_PER_FIELD = 10;
	localparam int BCD_W            = 4 * DIGITS_PER_FIELD;
	localparam int FIELDS           = 3;
	localparam int RECORD_BITS      = FIELDS * BCD_W;
	localparam int SEXTET_W         = 6;
	localparam int RECORD_CHARS     = RECORD_BITS / SEXTET_W;
	localparam int CHAR_CNT_W       = $clog2(RECORD_CHARS + 1);
	localparam int SHIFT_CNT_W      = $clog2(TS_W);
	localparam int FIELD_IDX_W      = $clog2(FIELDS);

	// tdata layout of the input item
	localparam int IN_TS_LSB  = 0;
	localparam int IN_TS_MSB  = 62;
	localparam int IN_OFF_LSB = 63;
	localparam int IN_OFF_MSB = 93;
	localparam int IN_LEN_LSB = 94;
	localparam int IN_LEN_MSB = 124;
	localparam int IN_DATA_W  = 128;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_CONV = 3'b010,
		ST_EMIT = 3'b100
	} kfb_state_t;

	typedef enum logic [FIELD_IDX_W-1:0] {
		FLD_TS  = 2'd0,
		FLD_OFF = 2'd1,
		FLD_LEN = 2'd2
	} kfb_field_t;

	// standard alphabet: A-Z a-z 0-9 + /
	function automatic logic [7:0] b64_char(input logic [SEXTET_W-1:0] s);
		logic [7:0] s8;
		logic [7:0] c;
		s8 = {2'b00, s};
		if (s8 < 8'd26) begin
			c = s8 + 8'd65;
		end else if (s8 < 8'd52) begin
			c = s8 + 8'd71;
		end else if (s8 < 8'd62) begin
			c = s8 - 8'd4;
		end else if (s8 == 8'd62) begin
			c = 8'd43;
		end else begin
			c = 8'd47;
		end
		return c;
	endfunction

endpackage

// ----- rtl/kfb_dabble.sv -----
// kfb_dabble: bit-serial binary to packed bcd converter (shift and add-3)
// one input bit per cycle; uses kfb_pkg
module kfb_dabble (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic [kfb_pkg::TS_W-1:0]          value,
	output logic                              done,
	output logic [kfb_pkg::BCD_W-1:0]         bcd
);

	logic                                busy_q;
	logic                                done_q;
	logic [kfb_pkg::SHIFT_CNT_W-1:0]     cnt_q;
	logic [kfb_pkg::TS_W-1:0]            bin_q;
	logic [kfb_pkg::BCD_W-1:0]           bcd_q;
	logic [kfb_pkg::BCD_W-1:0]           adj;

	// add 3 to every digit of 5 or more before the shift
	always_comb begin
		for (int i = 0; i < kfb_pkg::DIGITS_PER_FIELD; i++) begin
			adj[4*i +: 4] = (bcd_q[4*i +: 4] >= 4'd5) ? bcd_q[4*i +: 4] + 4'd3
				: bcd_q[4*i +: 4];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == kfb_pkg::SHIFT_CNT_W'(kfb_pkg::TS_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			bin_q <= value;
			bcd_q <= '0;
		end else if (busy_q) begin
			bin_q <= {bin_q[kfb_pkg::TS_W-2:0], 1'b0};
			bcd_q <= {adj[kfb_pkg::BCD_W-2:0], bin_q[kfb_pkg::TS_W-1]};
		end
	end

	assign done = done_q;
	assign bcd  = bcd_q;

endmodule

// ----- rtl/keyframe_meta_bcd_base64_packer_unit.sv -----
// Keyframe metadata packer: one record in (timestamp, offset, length), twenty
// base64 characters of its 15 packed bcd bytes out, one character per transfer.
// Flow: the block takes one record at a time and holds s_tready low until the
// twentieth character has been taken. The three values go in turn through one
// shared bit-serial bcd converter, each starting as the previous one finishes;
// the twenty characters then leave from a 120-bit shift register at one per
// cycle while m_tready is high. The timestamp is reduced to its low 33 bits.
// m_tlast marks the twentieth character of a record, m_tuser marks the
// twentieth character of a record that came in with s_tlast set.
// uses kfb_pkg and kfb_dabble
module keyframe_meta_bcd_base64_packer_unit (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// [62:0] timestamp_90khz, [93:63] byte_offset, [124:94] byte_length, zero pad
	input  logic [kfb_pkg::IN_DATA_W-1:0]     s_tdata,
	input  logic                              s_tlast,    // final_record
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// [7:0] base64_char
	output logic [7:0]                        m_tdata,
	output logic                              m_tlast,    // record_done
	output logic                              m_tuser     // [0] list_done
);

	kfb_pkg::kfb_state_t                 state_q;
	kfb_pkg::kfb_field_t                 field_q;
	logic [kfb_pkg::LEN_W-1:0]           off_q;
	logic [kfb_pkg::LEN_W-1:0]           len_q;
	logic                                final_q;
	logic [kfb_pkg::RECORD_BITS-1:0]     record_q;
	logic [kfb_pkg::CHAR_CNT_W-1:0]      char_cnt_q;
	logic                                m_valid_q;
	logic [7:0]                          m_data_q;
	logic                                m_last_q;
	logic                                m_user_q;

	logic                                in_xfer;
	logic                                conv_start;
	logic [kfb_pkg::TS_W-1:0]            conv_value;
	logic                                conv_done;
	logic [kfb_pkg::BCD_W-1:0]           conv_bcd;
	logic                                load_char;
	logic                                last_char;

	assign s_tready = (state_q == kfb_pkg::ST_IDLE);
	assign in_xfer  = s_tvalid && s_tready;

	// next field starts in the cycle the previous one finishes
	assign conv_start = in_xfer ||
		(state_q == kfb_pkg::ST_CONV && conv_done && field_q != kfb_pkg::FLD_LEN);

	always_comb begin
		if (state_q == kfb_pkg::ST_IDLE) begin
			conv_value = s_tdata[kfb_pkg::TS_W-1:0];
		end else if (field_q == kfb_pkg::FLD_TS) begin
			conv_value = {{(kfb_pkg::TS_W - kfb_pkg::LEN_W){1'b0}}, off_q};
		end else begin
			conv_value = {{(kfb_pkg::TS_W - kfb_pkg::LEN_W){1'b0}}, len_q};
		end
	end

	kfb_dabble u_dabble (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (conv_start),
		.value  (conv_value),
		.done   (conv_done),
		.bcd    (conv_bcd)
	);

	assign load_char = (state_q == kfb_pkg::ST_EMIT) && (!m_valid_q || m_tready) &&
		(char_cnt_q != kfb_pkg::CHAR_CNT_W'(kfb_pkg::RECORD_CHARS));
	assign last_char = (char_cnt_q == kfb_pkg::CHAR_CNT_W'(kfb_pkg::RECORD_CHARS - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= kfb_pkg::ST_IDLE;
			field_q    <= kfb_pkg::FLD_TS;
			char_cnt_q <= '0;
			m_valid_q  <= 1'b0;
		end else begin
			case (state_q)
				kfb_pkg::ST_IDLE: begin
					if (in_xfer) begin
						state_q <= kfb_pkg::ST_CONV;
						field_q <= kfb_pkg::FLD_TS;
					end
				end
				kfb_pkg::ST_CONV: begin
					if (conv_done) begin
						case (field_q)
							kfb_pkg::FLD_TS:  field_q <= kfb_pkg::FLD_OFF;
							kfb_pkg::FLD_OFF: field_q <= kfb_pkg::FLD_LEN;
							default: begin
								state_q    <= kfb_pkg::ST_EMIT;
								char_cnt_q <= '0;
							end
						endcase
					end
				end
				kfb_pkg::ST_EMIT: begin
					if (load_char) begin
						m_valid_q  <= 1'b1;
						char_cnt_q <= char_cnt_q + 1'b1;
					end else if (m_tready) begin
						m_valid_q <= 1'b0;
						if (m_valid_q && m_last_q) begin
							state_q <= kfb_pkg::ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= kfb_pkg::ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			off_q   <= s_tdata[kfb_pkg::IN_OFF_MSB:kfb_pkg::IN_OFF_LSB];
			len_q   <= s_tdata[kfb_pkg::IN_LEN_MSB:kfb_pkg::IN_LEN_LSB];
			final_q <= s_tlast;
		end
		// timestamp digits enter first and end up in the top bits
		if (state_q == kfb_pkg::ST_CONV && conv_done) begin
			record_q <= {record_q[kfb_pkg::RECORD_BITS-kfb_pkg::BCD_W-1:0], conv_bcd};
		end else if (load_char) begin
			record_q <= {record_q[kfb_pkg::RECORD_BITS-kfb_pkg::SEXTET_W-1:0],
				{kfb_pkg::SEXTET_W{1'b0}}};
		end
		if (load_char) begin
			m_data_q <= kfb_pkg::b64_char(
				record_q[kfb_pkg::RECORD_BITS-1 -: kfb_pkg::SEXTET_W]);
			m_last_q <= last_char;
			m_user_q <= last_char && final_q;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;
	assign m_tlast  = m_last_q;
	assign m_tuser  = m_user_q;

`ifndef SYNTH
	// no new record while a character of the previous one is pending
	a_ready_only_when_drained: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> !m_tvalid)
		else $error("input ready while output still valid");

	// the block frees itself right after the last character of a record
	a_ready_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && m_tlast |=> s_tready)
		else $error("not ready after last character transfer");

	a_list_done_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tlast)
		else $error("list_done without record_done");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("ready right after record transfer");
`endif

endmodule
